// ----- rtl/olid_pkg.sv -----
// Shared types and codes for the ordered list insert/delete block.
// Used by olid_ctrl and ordered_list_insert_delete; depends on nothing.
package olid_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 5;

  // Operation codes carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INS_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 2'd2;

  // Status codes returned with every result.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // One finished result handed from the controller to the output register.
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
    logic [VAL_W-1:0]  front;
  } res_t;

endpackage

// ----- rtl/ordered_list_insert_delete.sv -----
// Ordered list of signed 32-bit values with insert front/back and delete-first-match.
// Inserts and refused operations: result registered in the cycle after the input beat,
// one item per cycle while the output is not stalled. Delete of a list of n entries scans
// up to the first match (all n entries when the value is absent), then closes the gap;
// the single read port of the entry memory reads one entry per cycle. Reset clears the
// count and head pointer; the entry memory is not cleared and entries are only read after being written.
module ordered_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [olid_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [olid_pkg::VAL_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [olid_pkg::STAT_W-1:0]         status_o,
  output logic [olid_pkg::LEN_W-1:0]          length_o,
  output logic signed [olid_pkg::VAL_W-1:0]   front_value_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  olid_pkg::res_t               res;
  logic                         res_ready;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [olid_pkg::VAL_W-1:0]   mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [olid_pkg::VAL_W-1:0]   mem_rdata;

  logic                         out_valid_q;
  logic [olid_pkg::STAT_W-1:0]  status_q;
  logic [olid_pkg::LEN_W-1:0]   length_q;
  logic [olid_pkg::VAL_W-1:0]   front_q;

  // The output register may take a new result when it is empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  olid_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  olid_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (olid_pkg::VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      length_q <= res.length;
      front_q  <= res.front;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign length_o      = length_q;
  assign front_value_o = front_q;

endmodule

// ----- rtl/olid_ram.sv -----
// Entry memory of the ordered list: one write port, one read port, read data registered.
// Depends on nothing; instantiated by ordered_list_insert_delete.
module olid_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/olid_ctrl.sv -----
// Sequencer of the ordered list: circular head pointer, entry count, front copy,
// scan and gap-closing passes over the entry memory. Depends on olid_pkg.
module olid_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [olid_pkg::MODE_W-1:0]         mode_i,
  input  logic [olid_pkg::VAL_W-1:0]          value_i,
  input  logic                                res_ready_i,
  output olid_pkg::res_t                      res_o,
  output logic                                mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]         mem_waddr_o,
  output logic [olid_pkg::VAL_W-1:0]          mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(CAPACITY)-1:0]         mem_raddr_o,
  input  logic [olid_pkg::VAL_W-1:0]          mem_rdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = olid_pkg::LEN_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [AW-1:0]                head_q, head_d;
  logic [CW-1:0]                count_q, count_d;
  logic [olid_pkg::VAL_W-1:0]   front_q, front_d;
  logic [olid_pkg::VAL_W-1:0]   val_q, val_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                pidx_q, pidx_d;
  logic                         pend_q, pend_d;

  logic [AW-1:0]                head_m1;
  logic                         full;
  logic [CW-1:0]                last_idx;
  logic [LW+CW-1:0]             len_ext;

  // Logical position to memory address, wrapping around the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] ix);
    logic [CW:0] sum;
    sum = (CW+1)'(hd) + (CW+1)'(ix);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign head_m1  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign full     = (count_q == CW'(CAPACITY));
  assign last_idx = count_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    front_d     = front_q;
    val_d       = val_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pend_d      = pend_q;
    in_stall_o  = 1'b1;
    mem_we_o    = 1'b0;
    mem_waddr_o = head_q;
    mem_wdata_o = value_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    res_o.valid  = 1'b0;
    res_o.status = olid_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        in_stall_o = !res_ready_i;
        if (in_valid_i && res_ready_i) begin
          case (mode_i)
            olid_pkg::MODE_INS_FRONT: begin
              res_o.valid = 1'b1;
              if (full) begin
                res_o.status = olid_pkg::ST_FULL;
              end else begin
                head_d      = head_m1;
                mem_we_o    = 1'b1;
                mem_waddr_o = head_m1;
                front_d     = value_i;
                count_d     = count_q + CW'(1);
              end
            end
            olid_pkg::MODE_INS_BACK: begin
              res_o.valid = 1'b1;
              if (full) begin
                res_o.status = olid_pkg::ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = phys(head_q, count_q);
                if (count_q == '0) begin
                  front_d = value_i;
                end
                count_d = count_q + CW'(1);
              end
            end
            olid_pkg::MODE_DELETE: begin
              if (count_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = olid_pkg::ST_EMPTY;
              end else begin
                // Start the scan with a read of the front entry.
                val_d       = value_i;
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                pend_d      = 1'b1;
                pidx_d      = '0;
                idx_d       = CW'(1);
                state_d     = S_SCAN;
              end
            end
            default: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pend_q && mem_rdata_i == val_q) begin
          if (pidx_q == last_idx) begin
            // The match is the last entry: nothing moves.
            count_d     = last_idx;
            pend_d      = 1'b0;
            res_o.valid = 1'b1;
            state_d     = S_IDLE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = phys(head_q, pidx_q + CW'(1));
            pend_d      = 1'b1;
            pidx_d      = pidx_q + CW'(1);
            idx_d       = pidx_q + CW'(2);
            state_d     = S_SHIFT;
          end
        end else if (pend_q && pidx_q == last_idx) begin
          pend_d       = 1'b0;
          res_o.valid  = 1'b1;
          res_o.status = olid_pkg::ST_NOTFOUND;
          state_d      = S_IDLE;
        end else if (idx_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = phys(head_q, idx_q);
          pend_d      = 1'b1;
          pidx_d      = idx_q;
          idx_d       = idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      S_SHIFT: begin
        // Each beat of read data moves one entry a place toward the front.
        mem_we_o    = pend_q;
        mem_waddr_o = phys(head_q, pidx_q - CW'(1));
        mem_wdata_o = mem_rdata_i;
        if (pend_q && pidx_q == CW'(1)) begin
          front_d = mem_rdata_i;
        end
        if (idx_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = phys(head_q, idx_q);
          pend_d      = 1'b1;
          pidx_d      = idx_q;
          idx_d       = idx_q + CW'(1);
        end else begin
          pend_d      = 1'b0;
          count_d     = last_idx;
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        pend_d  = 1'b0;
      end
    endcase

    len_ext      = {{LW{1'b0}}, count_d};
    res_o.length = len_ext[LW-1:0];
    res_o.front  = (count_d == '0) ? '0 : front_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    val_q   <= val_d;
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < (AW+1)'(CAPACITY))
    else $error("head pointer outside the ring");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> state_q == S_IDLE)
    else $error("input beat taken while a delete is in progress");

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_ready_i)
    else $error("result produced while the output register is occupied");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && res_o.valid && res_o.status == olid_pkg::ST_OK
    |=> count_q == $past(count_q) - CW'(1))
    else $error("successful delete did not remove exactly one entry");

endmodule
